FILE: sv/dspa_pkg.sv
package dspa_pkg;

  localparam int unsigned PoolSize = 1024;
  localparam int unsigned IdW      = 10;
  localparam int unsigned CntW     = 11;

  typedef logic [IdW-1:0]  id_t;
  typedef logic [CntW-1:0] cnt_t;

  // Operation codes; code 3 decodes as a read.
  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_FREE  = 2'd1;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED  = 2'd1;
  localparam logic [1:0] ST_NOT_ACTIVE = 2'd2;
  localparam logic [1:0] ST_RANGE      = 2'd3;

  localparam cnt_t POOL_CNT = cnt_t'(PoolSize);

  typedef struct packed {
    cnt_t a;
    cnt_t b;
  } cmp_req_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_rsp_t;

endpackage

FILE: sv/dense_slot_pool_allocator.sv
// Slot pool allocator with a free stack and a dense list of active ids.
//
// Input channel (in_valid_i / in_ready_o) carries one item: func_i selects
// allocate, free node_id_i, or read the active list at list_index_i.
// Output channel (out_valid_o / out_ready_i) returns one result item per input
// item: status, slot id, active count after the operation, and list position.
//
// Every item is handled by a small sequencer around three single-port-read
// memories and one shared comparator. An allocate or a read passes through the
// look-up and completion steps, a free also through a second check step, because
// a free has to read the slot's position before it can read and check the list
// entry there. The block takes a new item only once it is idle again, after it
// loads the result, so it never takes an item before the last one is done.
//
// Reset empties the active list and fills the free stack with ids 0 to 1023.
// The free stack needs no clearing pass: a low-water mark of the stack depth
// tells which entries were never written, and those read as their own index.
// The output is a register: while the receiver stalls, the result is held and
// the next item may still be accepted; its result waits until the slot frees.
module dense_slot_pool_allocator
  import dspa_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] func_i,
  input  id_t        node_id_i,
  input  id_t        list_index_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] status_o,
  output id_t        slot_id_o,
  output cnt_t       active_count_o,
  output id_t        position_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_FREE2,
    S_DONE
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] func_q, func_d;
  id_t        nid_q, nid_d;
  id_t        idx_q, idx_d;
  id_t        pos_q, pos_d;
  id_t        last_q, last_d;
  cnt_t       total_q, total_d;
  cnt_t       fc_q, fc_d;
  cnt_t       lw_q, lw_d;
  logic [1:0] res_status_q, res_status_d;
  id_t        res_id_q, res_id_d;
  id_t        res_pos_q, res_pos_d;
  logic       out_valid_q, out_valid_d;
  logic [1:0] status_q, status_d;
  id_t        slot_id_q, slot_id_d;
  cnt_t       count_q, count_d;
  id_t        position_q, position_d;

  logic     accept;
  id_t      pop_idx;
  cmp_req_t cmp_req;
  cmp_rsp_t cmp_rsp;

  logic fs_we, al_we, sp_we;
  id_t  fs_waddr, fs_wdata, al_waddr, al_wdata, sp_waddr, sp_wdata;
  logic fs_re, al_re, sp_re;
  id_t  fs_raddr, al_raddr, sp_raddr;
  id_t  fs_rdata, al_rdata, sp_rdata;
  id_t  alloc_id;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i & in_ready_o;

  // Top of the free stack; entries below the low-water mark were never written.
  assign pop_idx = fc_q[IdW-1:0] - IdW'(1);

  // Reads are issued at acceptance; a free issues one more list read later.
  assign fs_re    = accept;
  assign fs_raddr = pop_idx;
  assign sp_re    = accept;
  assign sp_raddr = node_id_i;
  assign al_re    = accept || ((state_q == S_LOOK) && (func_q == FUNC_FREE));
  always_comb begin
    if (state_q == S_IDLE) begin
      al_raddr = (func_i == FUNC_FREE) ? (total_q[IdW-1:0] - IdW'(1)) : list_index_i;
    end else begin
      al_raddr = sp_rdata;
    end
  end

  dspa_ram u_free_stack (
    .clk_i   (clk_i),
    .we_i    (fs_we),
    .waddr_i (fs_waddr),
    .wdata_i (fs_wdata),
    .re_i    (fs_re),
    .raddr_i (fs_raddr),
    .rdata_o (fs_rdata)
  );

  dspa_ram u_active_list (
    .clk_i   (clk_i),
    .we_i    (al_we),
    .waddr_i (al_waddr),
    .wdata_i (al_wdata),
    .re_i    (al_re),
    .raddr_i (al_raddr),
    .rdata_o (al_rdata)
  );

  dspa_ram u_slot_position (
    .clk_i   (clk_i),
    .we_i    (sp_we),
    .waddr_i (sp_waddr),
    .wdata_i (sp_wdata),
    .re_i    (sp_re),
    .raddr_i (sp_raddr),
    .rdata_o (sp_rdata)
  );

  dspa_cmp u_cmp (
    .req_i (cmp_req),
    .rsp_o (cmp_rsp)
  );

  // Operands of the shared comparator, chosen by the step in progress.
  always_comb begin
    cmp_req.a = {1'b0, idx_q};
    cmp_req.b = total_q;
    case (state_q)
      S_LOOK: begin
        if (func_q == FUNC_ALLOC) begin
          cmp_req.a = {1'b0, pop_idx};
          cmp_req.b = lw_q;
        end else if (func_q == FUNC_FREE) begin
          cmp_req.a = {1'b0, sp_rdata};
          cmp_req.b = total_q;
        end
      end
      S_FREE2: begin
        cmp_req.a = {1'b0, al_rdata};
        cmp_req.b = {1'b0, nid_q};
      end
      default: begin
        cmp_req.a = {1'b0, idx_q};
        cmp_req.b = total_q;
      end
    endcase
  end

  assign alloc_id = cmp_rsp.lt ? pop_idx : fs_rdata;

  always_comb begin
    state_d      = state_q;
    func_d       = func_q;
    nid_d        = nid_q;
    idx_d        = idx_q;
    pos_d        = pos_q;
    last_d       = last_q;
    total_d      = total_q;
    fc_d         = fc_q;
    lw_d         = lw_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    res_pos_d    = res_pos_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    status_d     = status_q;
    slot_id_d    = slot_id_q;
    count_d      = count_q;
    position_d   = position_q;
    fs_we        = 1'b0;
    fs_waddr     = fc_q[IdW-1:0];
    fs_wdata     = nid_q;
    al_we        = 1'b0;
    al_waddr     = total_q[IdW-1:0];
    al_wdata     = alloc_id;
    sp_we        = 1'b0;
    sp_waddr     = alloc_id;
    sp_wdata     = total_q[IdW-1:0];

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          func_d  = func_i;
          nid_d   = node_id_i;
          idx_d   = list_index_i;
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        state_d = S_DONE;
        if (func_q == FUNC_ALLOC) begin
          if ((fc_q == '0) || (total_q == POOL_CNT)) begin
            res_status_d = ST_EXHAUSTED;
            res_id_d     = '0;
            res_pos_d    = '0;
          end else begin
            al_we        = 1'b1;
            sp_we        = 1'b1;
            total_d      = total_q + CntW'(1);
            fc_d         = fc_q - CntW'(1);
            lw_d         = cmp_rsp.lt ? {1'b0, pop_idx} : lw_q;
            res_status_d = ST_OK;
            res_id_d     = alloc_id;
            res_pos_d    = total_q[IdW-1:0];
          end
        end else if (func_q == FUNC_FREE) begin
          res_id_d  = nid_q;
          res_pos_d = '0;
          if (cmp_rsp.lt) begin
            // Position is inside the list; the entry there is checked next.
            pos_d   = sp_rdata;
            last_d  = al_rdata;
            state_d = S_FREE2;
          end else begin
            res_status_d = ST_NOT_ACTIVE;
          end
        end else begin
          if (cmp_rsp.lt) begin
            res_status_d = ST_OK;
            res_id_d     = al_rdata;
            res_pos_d    = idx_q;
          end else begin
            res_status_d = ST_RANGE;
            res_id_d     = '0;
            res_pos_d    = '0;
          end
        end
      end
      S_FREE2: begin
        state_d = S_DONE;
        if (cmp_rsp.eq) begin
          // The last entry moves into the hole; when the freed id was last
          // this rewrites an entry that is past the new end of the list.
          al_we    = 1'b1;
          al_waddr = pos_q;
          al_wdata = last_q;
          sp_we    = 1'b1;
          sp_waddr = last_q;
          sp_wdata = pos_q;
          total_d  = total_q - CntW'(1);
          if (fc_q != POOL_CNT) begin
            fs_we = 1'b1;
            fc_d  = fc_q + CntW'(1);
          end
          res_status_d = ST_OK;
        end else begin
          res_status_d = ST_NOT_ACTIVE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          status_d    = res_status_q;
          slot_id_d   = res_id_q;
          count_d     = total_q;
          position_d  = res_pos_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      total_q     <= '0;
      fc_q        <= POOL_CNT;
      lw_q        <= POOL_CNT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      fc_q        <= fc_d;
      lw_q        <= lw_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    nid_q        <= nid_d;
    idx_q        <= idx_d;
    pos_q        <= pos_d;
    last_q       <= last_d;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    res_pos_q    <= res_pos_d;
    status_q     <= status_d;
    slot_id_q    <= slot_id_d;
    count_q      <= count_d;
    position_q   <= position_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign slot_id_o      = slot_id_q;
  assign active_count_o = count_q;
  assign position_o     = position_q;

  // Every id is either on the free stack or in the active list.
  a_conserve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (total_q + fc_q) == POOL_CNT)
    else $error("free and active counts do not add up to the pool size");

  // The low-water mark never rises above the current stack depth.
  a_low_water: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lw_q <= fc_q)
    else $error("free stack low-water mark above stack depth");

  // A new result is only loaded from the completion step.
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_DONE) && !(out_valid_q && !out_ready_i) |=> !out_valid_q)
    else $error("result presented without a finished item");

endmodule

FILE: sv/dspa_ram.sv
module dspa_ram
  import dspa_pkg::*;
(
  input  logic clk_i,
  input  logic we_i,
  input  id_t  waddr_i,
  input  id_t  wdata_i,
  input  logic re_i,
  input  id_t  raddr_i,
  output id_t  rdata_o
);

  id_t mem_q [PoolSize];
  id_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/dspa_cmp.sv
module dspa_cmp
  import dspa_pkg::*;
(
  input  cmp_req_t req_i,
  output cmp_rsp_t rsp_o
);

  // Shared magnitude and equality compare used by the look-up and free-check steps.
  assign rsp_o.lt = (req_i.a < req_i.b);
  assign rsp_o.eq = (req_i.a == req_i.b);

endmodule
